/* hw/rtl/slbc_pkg.sv */
// ----------------------------------------------------------------------------
// slbc_pkg
// Types, constants and helper functions shared by the speed limit brake
// controller modules.
// ----------------------------------------------------------------------------
package slbc_pkg;

  // Transaction kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Characters seen by the packet parser
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Magnitude saturation point of the number reader
  localparam logic [16:0] ACC_SAT = 17'd32768;

  // Reset values
  localparam logic [15:0] RST_BRAKE_RELEASE = 16'd9900;
  localparam logic [9:0]  RST_BRAKE_GAIN    = 10'd12;
  localparam logic [15:0] RST_BRAKE_FLOOR   = 16'd0;
  localparam logic [11:0] RST_PERIOD_LIMIT  = 12'd1000;
  localparam logic [7:0]  RST_WINDOW_LIMIT  = 8'd10;
  localparam logic [11:0] RST_SPEED_KMH     = 12'd15;

  // ceil(18 * 2^32 / 575): speed = (edges * SPEED_RECIP) >> 32 equals
  // floor(edges * 18 / 575) for every 16-bit edge count
  localparam logic [27:0] SPEED_RECIP = 28'd134451151;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BRAKE_RELEASE = 3'd0,
    CFG_BRAKE_GAIN    = 3'd1,
    CFG_BRAKE_FLOOR   = 3'd2,
    CFG_PERIOD_LIMIT  = 3'd3,
    CFG_WINDOW_LIMIT  = 3'd4
  } cfg_idx_t;

  // Parser field phase
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_TOKEN  = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic [2:0] hall_bits;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        brake_compare;
    logic [11:0]        measured_speed;
    logic signed [15:0] speed_target;
    logic               brake_updated;
    logic               speed_updated;
  } out_item_t;

  typedef struct packed {
    logic [15:0] brake_release;
    logic [9:0]  brake_gain;
    logic [15:0] brake_floor;
  } brake_cfg_t;

  typedef struct packed {
    logic [11:0] period_limit;
    logic [7:0]  window_limit;
  } window_cfg_t;

  typedef struct packed {
    logic [15:0]        brake_compare;
    logic signed [15:0] speed_target;
    logic               brake_updated;
  } brake_res_t;

  typedef struct packed {
    logic [11:0] measured_speed;
    logic        speed_updated;
  } speed_res_t;

  function automatic logic [11:0] speed_from_edges(input logic [15:0] edges);
    logic [43:0] prod;
    prod = 44'(edges) * 44'(SPEED_RECIP);
    return prod[43:32];
  endfunction

endpackage

/* hw/rtl/slbc_parser.sv */
// ----------------------------------------------------------------------------
// slbc_parser
// Streaming packet reader: reads the first field as a number and recomputes
// the brake compare value when a packet closes.
// ----------------------------------------------------------------------------
module slbc_parser import slbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [11:0] speed_kmh,
  input  brake_cfg_t  cfg,
  output brake_res_t  res
);

  logic               open_r,  open_nxt;
  phase_t             ph_r,    ph_nxt;
  logic               tok_r,   tok_nxt;
  logic               neg_r,   neg_nxt;
  logic [16:0]        acc_r,   acc_nxt;
  logic signed [15:0] tgt_r,   tgt_nxt;
  logic [15:0]        brake_r, brake_nxt;
  logic               upd;

  logic               is_sep, is_space, is_digit;
  logic               tok_stage, dig_stage;
  logic [18:0]        acc_mul;
  logic [16:0]        acc_neg;
  logic signed [15:0] tgt_close;
  logic signed [17:0] diff_s;
  logic [25:0]        sub;
  logic [15:0]        rel_left;
  logic [15:0]        brake_close;

  assign is_sep   = (rx_byte == CH_COMMA) || (rx_byte == CH_STAR);
  assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign acc_mul  = 19'(acc_r) * 19'd10 + 19'(rx_byte - CH_ZERO);

  // Field reader, one character per transaction
  always_comb begin
    ph_nxt    = ph_r;
    tok_nxt   = tok_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    tok_stage = 1'b0;
    dig_stage = 1'b0;
    if (rx_byte == CH_NUL) begin
      ph_nxt = PH_DONE;
    end else begin
      unique case (ph_r)
        PH_SKIP: begin
          if (!is_sep) begin
            tok_nxt   = 1'b1;
            ph_nxt    = PH_TOKEN;
            tok_stage = 1'b1;
          end
        end
        PH_TOKEN:  tok_stage = 1'b1;
        PH_DIGITS: dig_stage = 1'b1;
        PH_DONE:   ;
        default:   ;
      endcase
      if (tok_stage) begin
        priority if (is_sep) begin
          ph_nxt = PH_DONE;
        end else if (is_space) begin
          ph_nxt = PH_TOKEN;
        end else if ((rx_byte == CH_MINUS) || (rx_byte == CH_PLUS)) begin
          neg_nxt = (rx_byte == CH_MINUS);
          ph_nxt  = PH_DIGITS;
        end else begin
          ph_nxt    = PH_DIGITS;
          dig_stage = 1'b1;
        end
      end
      if (dig_stage) begin
        if (is_digit) begin
          acc_nxt = (acc_mul > 19'(ACC_SAT)) ? ACC_SAT : acc_mul[16:0];
        end else begin
          ph_nxt = PH_DONE;
        end
      end
    end
  end

  // Target and brake value at packet close
  assign acc_neg = 17'd0 - acc_nxt;

  // A closing byte with no open packet is not parsed, so hold the old target
  always_comb begin
    if (!open_r || !tok_nxt) begin
      tgt_close = tgt_r;
    end else if (neg_nxt) begin
      tgt_close = acc_neg[15:0];
    end else if (acc_nxt > 17'd32767) begin
      tgt_close = 16'sd32767;
    end else begin
      tgt_close = acc_nxt[15:0];
    end
  end

  assign diff_s   = $signed({6'b0, speed_kmh}) - 18'(tgt_close);
  assign sub      = 26'(cfg.brake_gain) * 26'(diff_s[15:0]);
  assign rel_left = cfg.brake_release - sub[15:0];

  always_comb begin
    if (diff_s[17] || (diff_s == 18'sd0)) begin
      brake_close = cfg.brake_release;
    end else if ((sub > 26'(cfg.brake_release)) || (rel_left < cfg.brake_floor)) begin
      brake_close = cfg.brake_floor;
    end else begin
      brake_close = rel_left;
    end
  end

  // Packet framing
  always_comb begin
    open_nxt  = open_r;
    brake_nxt = brake_r;
    tgt_nxt   = tgt_r;
    upd       = 1'b0;
    if (step && (rx_byte == CH_DOLLAR)) begin
      open_nxt = 1'b1;
    end else if (step && (rx_byte == CH_HASH)) begin
      open_nxt  = 1'b0;
      brake_nxt = brake_close;
      tgt_nxt   = tgt_close;
      upd       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      ph_r    <= PH_SKIP;
      tok_r   <= 1'b0;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      tgt_r   <= '0;
      brake_r <= RST_BRAKE_RELEASE;
    end else begin
      open_r  <= open_nxt;
      tgt_r   <= tgt_nxt;
      brake_r <= brake_nxt;
      if (step && (rx_byte == CH_HASH)) begin
        ph_r  <= PH_SKIP;
        tok_r <= 1'b0;
        neg_r <= 1'b0;
        acc_r <= '0;
      end else if (step && open_r && (rx_byte != CH_DOLLAR)) begin
        ph_r  <= ph_nxt;
        tok_r <= tok_nxt;
        neg_r <= neg_nxt;
        acc_r <= acc_nxt;
      end
    end
  end

  assign res.brake_compare = brake_nxt;
  assign res.speed_target  = tgt_nxt;
  assign res.brake_updated = upd;

endmodule

/* hw/rtl/slbc_speed.sv */
// ----------------------------------------------------------------------------
// slbc_speed
// Hall edge counter and speed window timer.
// ----------------------------------------------------------------------------
module slbc_speed import slbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [2:0]  hall_bits,
  input  window_cfg_t cfg,
  output logic [11:0] speed_kmh,
  output speed_res_t  res
);

  logic [2:0]  hall_r,  hall_nxt;
  logic [15:0] edge_r,  edge_nxt;
  logic [12:0] per_r,   per_nxt;
  logic [7:0]  win_r,   win_nxt;
  logic [11:0] speed_r, speed_nxt;
  logic        upd;

  logic [12:0] per_inc;
  logic [15:0] edge_inc;
  logic [7:0]  win_inc;

  assign per_inc = per_r + 13'd2;

  always_comb begin
    edge_inc = edge_r;
    if ((hall_bits != hall_r) && (hall_bits != 3'd0) && (edge_r != 16'hFFFF)) begin
      edge_inc = edge_r + 16'd1;
    end
  end

  always_comb begin
    hall_nxt  = hall_r;
    edge_nxt  = edge_r;
    per_nxt   = per_r;
    win_nxt   = win_r;
    speed_nxt = speed_r;
    upd       = 1'b0;
    win_inc   = win_r;
    if (step) begin
      hall_nxt = hall_bits;
      per_nxt  = per_inc;
      if (per_inc > 13'(cfg.period_limit)) begin
        win_inc = win_r + 8'd1;
        per_nxt = '0;
      end
      win_nxt  = win_inc;
      edge_nxt = edge_inc;
      if (win_inc > cfg.window_limit) begin
        speed_nxt = speed_from_edges(edge_inc);
        edge_nxt  = '0;
        win_nxt   = '0;
        upd       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hall_r  <= '0;
      edge_r  <= '0;
      per_r   <= '0;
      win_r   <= '0;
      speed_r <= RST_SPEED_KMH;
    end else begin
      hall_r  <= hall_nxt;
      edge_r  <= edge_nxt;
      per_r   <= per_nxt;
      win_r   <= win_nxt;
      speed_r <= speed_nxt;
    end
  end

  assign speed_kmh          = speed_r;
  assign res.measured_speed = speed_nxt;
  assign res.speed_updated  = upd;

endmodule

/* hw/rtl/speed_limit_brake_controller.sv */
// ----------------------------------------------------------------------------
// speed_limit_brake_controller
// Serial packet target reader, hall speed meter and brake compare update.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Direction  Transaction
//  in       in_valid / in_ready / in_data  input      serial byte or tick
//  out      out_valid/out_ready/out_data   output     one result per input
//  cfg      cfg_we / cfg_index / cfg_wdata input      register write, no wait
//
//  Each transaction passes through the input register, then through the
//  update logic into the result register.
//  A new transaction can be taken every cycle while out_ready is high; the
//  path from input register to result register (parser, one 10x16 brake
//  multiply, reciprocal speed multiply) sets the clock rate.
//  Reset (rst_n low, synchronous) clears both pipeline stages and restores
//  the state and config registers; stage data registers have no reset.
//  A stall on out_ready holds the result register; the input register then
//  holds too, and in_ready drops only when both are full.
//
module speed_limit_brake_controller import slbc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers
  brake_cfg_t  bcfg_r;
  window_cfg_t wcfg_r;

  // Input stage
  logic     s1_vld_r;
  in_item_t s1_data_r;

  // Result stage
  logic      out_vld_r;
  out_item_t out_data_r;

  logic        adv;
  logic        step_byte, step_tick;
  logic [11:0] speed_kmh;
  brake_res_t  brk_res;
  speed_res_t  spd_res;

  // Advance the input stage into the result stage when the result register
  // is empty or being drained this cycle
  assign adv       = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !s1_vld_r || adv;
  assign step_byte = adv && (s1_data_r.kind == KIND_BYTE);
  assign step_tick = adv && (s1_data_r.kind == KIND_TICK);

  // Write configuration; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcfg_r.brake_release <= RST_BRAKE_RELEASE;
      bcfg_r.brake_gain    <= RST_BRAKE_GAIN;
      bcfg_r.brake_floor   <= RST_BRAKE_FLOOR;
      wcfg_r.period_limit  <= RST_PERIOD_LIMIT;
      wcfg_r.window_limit  <= RST_WINDOW_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BRAKE_RELEASE: bcfg_r.brake_release <= cfg_wdata;
        CFG_BRAKE_GAIN:    bcfg_r.brake_gain    <= cfg_wdata[9:0];
        CFG_BRAKE_FLOOR:   bcfg_r.brake_floor   <= cfg_wdata;
        CFG_PERIOD_LIMIT:  wcfg_r.period_limit  <= cfg_wdata[11:0];
        CFG_WINDOW_LIMIT:  wcfg_r.window_limit  <= cfg_wdata[7:0];
        default:           ;
      endcase
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  slbc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_byte),
    .rx_byte   (s1_data_r.rx_byte),
    .speed_kmh (speed_kmh),
    .cfg       (bcfg_r),
    .res       (brk_res)
  );

  slbc_speed u_speed (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step_tick),
    .hall_bits (s1_data_r.hall_bits),
    .cfg       (wcfg_r),
    .speed_kmh (speed_kmh),
    .res       (spd_res)
  );

  // Hold the result until taken; load a fresh one on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.brake_compare  <= brk_res.brake_compare;
      out_data_r.measured_speed <= spd_res.measured_speed;
      out_data_r.speed_target   <= brk_res.speed_target;
      out_data_r.brake_updated  <= brk_res.brake_updated;
      out_data_r.speed_updated  <= spd_res.speed_updated;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_hash_updates_brake: assert property (@(posedge clk) disable iff (!rst_n)
    (step_byte && (s1_data_r.rx_byte == CH_HASH)) |=> out_data.brake_updated)
    else $error("closing byte did not flag a brake update");

  a_tick_no_brake: assert property (@(posedge clk) disable iff (!rst_n)
    step_tick |-> !brk_res.brake_updated)
    else $error("brake updated on a timer tick");

  a_byte_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
    step_byte |-> !spd_res.speed_updated)
    else $error("speed window closed on a serial byte");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled while a stage was free");
`endif

endmodule
